// ===== src/bhv_pkg.sv =====
// Shared types, constants and status codes for the BMP header validator.
// Depends on nothing; every other file in src takes it in by wildcard import.
package bhv_pkg;

    localparam int WORD_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 6;
    localparam int DIGIT_W  = 4;
    localparam int DIGITS   = WORD_W / DIGIT_W;
    localparam int DCNT_W   = $clog2(DIGITS + 1);
    localparam int STATUS_W = 4;

    // Header byte positions at which a field is complete.
    localparam logic [POS_W-1:0] POS_SIG        = 6'd1;
    localparam logic [POS_W-1:0] POS_FILE_SIZE  = 6'd5;
    localparam logic [POS_W-1:0] POS_RES1       = 6'd7;
    localparam logic [POS_W-1:0] POS_RES2       = 6'd9;
    localparam logic [POS_W-1:0] POS_OFFSET     = 6'd13;
    localparam logic [POS_W-1:0] POS_HDR_SIZE   = 6'd17;
    localparam logic [POS_W-1:0] POS_WIDTH      = 6'd21;
    localparam logic [POS_W-1:0] POS_HEIGHT     = 6'd25;
    localparam logic [POS_W-1:0] POS_PLANES     = 6'd27;
    localparam logic [POS_W-1:0] POS_BPP        = 6'd29;
    localparam logic [POS_W-1:0] POS_COMPR      = 6'd33;
    localparam logic [POS_W-1:0] POS_IMG_SIZE   = 6'd37;
    localparam logic [POS_W-1:0] POS_USED       = 6'd49;
    localparam logic [POS_W-1:0] POS_IMPORTANT  = 6'd53;
    localparam logic [POS_W-1:0] POS_LAST       = 6'd53;

    localparam logic [15:0]       SIGNATURE_BM   = 16'h4D42;
    localparam logic [WORD_W-1:0] PIXEL_OFFSET   = 32'h0000_0036;
    localparam logic [WORD_W-1:0] INFO_HDR_SIZE  = 32'h0000_0028;
    localparam logic [15:0]       PLANES_ONE     = 16'h0001;
    localparam logic [15:0]       BPP_24         = 16'h0018;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 4'd0,
        ST_SIG       = 4'd1,
        ST_RES1      = 4'd2,
        ST_RES2      = 4'd3,
        ST_OFFSET    = 4'd4,
        ST_HDR_SIZE  = 4'd5,
        ST_BOTTOM_UP = 4'd6,
        ST_PLANES    = 4'd7,
        ST_BPP       = 4'd8,
        ST_COMPR     = 4'd9,
        ST_IMG_SIZE  = 4'd10,
        ST_USED      = 4'd11,
        ST_IMPORTANT = 4'd12
    } bhv_status_t;

    // Start of a row-size times height product.
    typedef struct packed {
        logic              load;
        logic [WORD_W-1:0] row;
        logic [WORD_W-1:0] height;
    } bhv_mul_req_t;

    // Completed header, handed to the output stage for one cycle.
    typedef struct packed {
        logic              valid;
        bhv_status_t       status;
        logic [WORD_W-1:0] file_size;
        logic [WORD_W-1:0] width;
        logic [WORD_W-1:0] height;
        logic [WORD_W-1:0] pixel_bytes;
    } bhv_result_t;

endpackage

// ===== src/bhv_serial_mult.sv =====
// Digit-serial multiplier, one 4-bit digit of the multiplier per cycle, MSB first.
// Depends on bhv_pkg; the product wraps to 32 bits.
module bhv_serial_mult
    import bhv_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  bhv_mul_req_t      req,
    output logic [WORD_W-1:0] product
);

    logic [WORD_W-1:0]         mcand_reg;
    logic [WORD_W-1:0]         mplier_reg;
    logic [WORD_W-1:0]         acc_reg;
    logic [WORD_W-1:0]         acc_next;
    logic [DCNT_W-1:0]         cnt_reg;
    logic [WORD_W+DIGIT_W-1:0] partial;

    assign partial  = mcand_reg * mplier_reg[WORD_W-1 -: DIGIT_W];
    assign acc_next = {acc_reg[WORD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}}
                      + partial[WORD_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (req.load) begin
            cnt_reg <= DCNT_W'(DIGITS);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.load) begin
            mcand_reg  <= req.row;
            mplier_reg <= req.height;
            acc_reg    <= '0;
        end else if (cnt_reg != '0) begin
            mplier_reg <= {mplier_reg[WORD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            acc_reg    <= acc_next;
        end
    end

    assign product = acc_reg;

endmodule

// ===== src/bhv_byte_parser.sv =====
// Byte-serial header parser: shifts bytes into a 32-bit window and runs each check.
// Depends on bhv_pkg and bhv_serial_mult for the image size product.
module bhv_byte_parser
    import bhv_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_valid,
    input  logic [BYTE_W-1:0] header_byte,
    input  logic              start_of_header,
    output bhv_result_t       result
);

    logic [WORD_W-1:0] window_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              active_reg;
    bhv_status_t       first_error_reg;
    logic [WORD_W-1:0] file_size_reg;
    logic [WORD_W-1:0] width_reg;
    logic [WORD_W-1:0] height_reg;
    logic [WORD_W-1:0] pixel_reg;
    logic              result_valid_reg;

    logic [WORD_W-1:0] window_next;
    logic [15:0]       hi16;
    logic [POS_W-1:0]  pos;
    logic              take;
    bhv_status_t       err_base;
    bhv_status_t       err_now;
    bhv_status_t       err_next;
    logic [WORD_W-1:0] row_size;
    logic [WORD_W-1:0] product;
    bhv_mul_req_t      mul_req;

    // A start discards the partial window, so the new byte lands on zeros.
    assign window_next = {header_byte, start_of_header ? {(WORD_W-BYTE_W){1'b0}}
                                                       : window_reg[WORD_W-1:BYTE_W]};
    assign hi16     = window_next[WORD_W-1:16];
    assign pos      = start_of_header ? '0 : pos_reg;
    assign take     = byte_valid && (start_of_header || active_reg);
    assign err_base = start_of_header ? ST_OK : first_error_reg;

    always_comb begin
        err_now = ST_OK;
        unique case (pos)
            POS_SIG:       if (hi16 != SIGNATURE_BM)       err_now = ST_SIG;
            POS_RES1:      if (hi16 != 16'h0000)           err_now = ST_RES1;
            POS_RES2:      if (hi16 != 16'h0000)           err_now = ST_RES2;
            POS_OFFSET:    if (window_next != PIXEL_OFFSET)  err_now = ST_OFFSET;
            POS_HDR_SIZE:  if (window_next != INFO_HDR_SIZE) err_now = ST_HDR_SIZE;
            POS_HEIGHT:    if (!window_next[WORD_W-1])     err_now = ST_BOTTOM_UP;
            POS_PLANES:    if (hi16 != PLANES_ONE)         err_now = ST_PLANES;
            POS_BPP:       if (hi16 != BPP_24)             err_now = ST_BPP;
            POS_COMPR:     if (window_next != '0)          err_now = ST_COMPR;
            POS_IMG_SIZE:  if (window_next != product)     err_now = ST_IMG_SIZE;
            POS_USED:      if (window_next != '0)          err_now = ST_USED;
            POS_IMPORTANT: if (window_next != '0)          err_now = ST_IMPORTANT;
            default:       err_now = ST_OK;
        endcase
    end

    assign err_next = (err_base != ST_OK) ? err_base : err_now;

    // Padded row size: width*3 + 3, rounded down to a multiple of four.
    assign row_size = ({width_reg[WORD_W-2:0], 1'b0} + width_reg + WORD_W'(3))
                      & ~WORD_W'(3);

    assign mul_req.load   = take && (pos == POS_HEIGHT);
    assign mul_req.row    = row_size;
    assign mul_req.height = '0 - window_next;

    bhv_serial_mult u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .product (product)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg          <= '0;
            active_reg       <= 1'b0;
            first_error_reg  <= ST_OK;
            result_valid_reg <= 1'b0;
        end else begin
            result_valid_reg <= 1'b0;
            if (take) begin
                first_error_reg <= err_next;
                if (pos == POS_LAST) begin
                    pos_reg          <= '0;
                    active_reg       <= 1'b0;
                    result_valid_reg <= 1'b1;
                end else begin
                    pos_reg    <= pos + 1'b1;
                    active_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            window_reg <= window_next;
            if (pos == POS_FILE_SIZE) begin
                file_size_reg <= window_next;
            end
            if (pos == POS_WIDTH) begin
                width_reg <= window_next;
            end
            if (pos == POS_HEIGHT) begin
                height_reg <= mul_req.height;
            end
            if (pos == POS_IMG_SIZE) begin
                pixel_reg <= window_next;
            end
        end
    end

    assign result.valid       = result_valid_reg;
    assign result.status      = first_error_reg;
    assign result.file_size   = file_size_reg;
    assign result.width       = width_reg;
    assign result.height      = height_reg;
    assign result.pixel_bytes = pixel_reg;

endmodule

// ===== src/bmp_header_validator.sv =====
// Top level of the BMP header validator: stream ports and the result register.
// Depends on bhv_pkg and bhv_byte_parser (which holds bhv_serial_mult).
//
// Usage: the 54 bytes of a BMP file header and BITMAPINFOHEADER arrive on the
// slave channel, one byte per request in s_tdata, with s_tuser high on byte 0.
// A request with s_tuser high always restarts parsing and drops any partial
// header; bytes that arrive while no header is open are taken and ignored.
// After the 54th byte one request leaves on the master channel carrying the
// status of the first failed check and, when every check passed, the file
// size, width, negated height and image size (all zero otherwise).
// Throughput: one byte per cycle while s_tready is high. The image size check
// needs the padded row size times the height; a digit-serial multiplier forms
// it one digit at a time, starting on the height byte, and the twelve bytes
// up to the image size check always give it time to finish.
// After the 54th byte is taken, the result passes the parser's result register
// and then the output result register before m_tvalid rises.
// Reset (aresetn low at a clock edge) closes any open header and drops an
// undelivered result. While a result waits on m_tready, s_tready is held low,
// so no byte is taken until the result register is free again.
module bmp_header_validator
    import bhv_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] header_byte
    input  logic         s_tuser,   // [0] start_of_header
    output logic         m_tvalid,
    input  logic         m_tready,
    // [3:0] status, [35:4] file_size, [67:36] image_width,
    // [99:68] image_height, [131:100] pixel_bytes, [135:132] zero
    output logic [135:0] m_tdata
);

    localparam int OUT_BITS = STATUS_W + 4 * WORD_W;

    bhv_result_t         result;
    logic                m_valid_reg;
    logic [OUT_BITS-1:0] m_data_reg;
    logic                ok;
    logic [WORD_W-1:0]   keep_mask;

    // The result register is free when empty or being emptied this cycle.
    assign s_tready = !m_valid_reg || m_tready;

    bhv_byte_parser u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .byte_valid      (s_tvalid && s_tready),
        .header_byte     (s_tdata),
        .start_of_header (s_tuser),
        .result          (result)
    );

    // Header values are only reported for a header that passed every check.
    assign ok        = (result.status == ST_OK);
    assign keep_mask = {WORD_W{ok}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (result.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.valid) begin
            m_data_reg <= {result.pixel_bytes & keep_mask,
                           result.height      & keep_mask,
                           result.width       & keep_mask,
                           result.file_size   & keep_mask,
                           result.status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_data_reg};

endmodule

// ===== dv/bmp_header_validator_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bmp_header_validator: streams BMP headers byte by byte
// and checks every result request against a behavioural header parser of its own.
// Depends on bhv_pkg (status codes) and the RTL in src; it reads no files.
module bmp_header_validator_test;
    import bhv_pkg::*;

    localparam int HDR_LEN        = 54;
    localparam int HDR_BITS       = HDR_LEN * 8;
    localparam int RANDOM_BYTES   = 220;
    localparam int RANDOM_REPORTS = 3;

    // Values that a valid 24-bit top-down header carries.
    localparam logic [15:0] BM_MAGIC    = 16'h4D42;
    localparam logic [31:0] DATA_OFFSET = 32'd54;
    localparam logic [31:0] INFO_SIZE   = 32'd40;
    localparam logic [15:0] ONE_PLANE   = 16'd1;
    localparam logic [15:0] TRUE_COLOUR = 16'd24;

    // The header as it sits in the file. The last field is declared first, so that
    // byte i of the flattened header lies in bits [8i+7:8i] and every field comes
    // out little-endian.
    typedef struct packed {
        logic [31:0] important;
        logic [31:0] used;
        logic [31:0] yres;
        logic [31:0] xres;
        logic [31:0] img_size;
        logic [31:0] compr;
        logic [15:0] bpp;
        logic [15:0] planes;
        logic [31:0] height;
        logic [31:0] width;
        logic [31:0] info_size;
        logic [31:0] offset;
        logic [15:0] res2;
        logic [15:0] res1;
        logic [31:0] file_size;
        logic [15:0] sig;
    } bmp_hdr_t;

    // What one completed header should produce on the result channel.
    typedef struct packed {
        bhv_status_t status;
        logic [31:0] file_size;
        logic [31:0] width;
        logic [31:0] height;
        logic [31:0] pixel_bytes;
    } hdr_report_t;

    // One directed case: idle bytes sent beforehand, the check that is broken (and
    // the XOR pattern that breaks it), the image shape, and how many bytes are sent
    // before the next header restarts parsing (zero for the whole header). Where
    // typed is set, the expected status is the broken check itself and every other
    // field is zero.
    typedef struct packed {
        int          noise;
        bhv_status_t broken;
        logic [31:0] mask;
        logic [31:0] width;
        logic [31:0] height;
        int          cut;
        bit          typed;
    } dir_row_t;

    dir_row_t directed_rows [23] = '{
        // Smallest image, straight after reset, with ignored bytes before it.
        '{2, ST_OK,        32'h0,         32'd1,         32'hFFFF_FFFF, 0,  1'b0},
        '{0, ST_OK,        32'h0,         32'd0,         32'hFFFF_FFFF, 0,  1'b0},
        // Widest image and the most negative height: the row size wraps to zero.
        '{0, ST_OK,        32'h0,         32'hFFFF_FFFF, 32'h8000_0000, 0,  1'b0},
        '{0, ST_OK,        32'h0,         32'd3,         32'hFFFF_FFFE, 0,  1'b0},
        '{0, ST_SIG,       32'h0000_FFFF, 32'd7,         32'hFFFF_FFFD, 0,  1'b1},
        // Signature and height both wrong: the lower code wins.
        '{0, ST_SIG,       32'h0000_0100, 32'd7,         32'd5,         0,  1'b1},
        '{0, ST_RES1,      32'h0000_FFFF, 32'd7,         32'hFFFF_FFFD, 0,  1'b1},
        '{0, ST_RES2,      32'h0000_8000, 32'd7,         32'hFFFF_FFFD, 0,  1'b1},
        '{0, ST_OFFSET,    32'hFFFF_FFFF, 32'd7,         32'hFFFF_FFFD, 0,  1'b1},
        '{0, ST_HDR_SIZE,  32'h0000_0054, 32'd7,         32'hFFFF_FFFD, 0,  1'b1},
        '{0, ST_BOTTOM_UP, 32'h7FFF_FFFF, 32'd7,         32'hFFFF_FFFD, 0,  1'b1},
        // A height of zero is not negative either.
        '{0, ST_BOTTOM_UP, 32'h0,         32'd7,         32'hFFFF_FFFD, 0,  1'b1},
        '{0, ST_PLANES,    32'h0000_0001, 32'd7,         32'hFFFF_FFFD, 0,  1'b1},
        '{0, ST_BPP,       32'h0000_0038, 32'd7,         32'hFFFF_FFFD, 0,  1'b1},
        '{0, ST_COMPR,     32'h0000_0001, 32'd7,         32'hFFFF_FFFD, 0,  1'b1},
        '{0, ST_IMG_SIZE,  32'h0000_0004, 32'd7,         32'hFFFF_FFFD, 0,  1'b1},
        '{0, ST_USED,      32'h0000_0100, 32'd7,         32'hFFFF_FFFD, 0,  1'b1},
        '{0, ST_IMPORTANT, 32'hFFFF_FFFF, 32'd7,         32'hFFFF_FFFD, 0,  1'b1},
        // Headers abandoned part-way, one of them just before its final byte.
        '{0, ST_OK,        32'h0,         32'd5,         32'hFFFF_FFFC, 30, 1'b0},
        '{0, ST_OK,        32'h0,         32'd5,         32'hFFFF_FFFC, 53, 1'b0},
        '{0, ST_OK,        32'h0,         32'd2,         32'hFFFF_FFFE, 1,  1'b0},
        '{0, ST_OK,        32'h0,         32'd2,         32'hFFFF_FFFE, 0,  1'b0},
        // Bytes that arrive after a finished header must be ignored.
        '{3, ST_OK,        32'h0,         32'd9,         32'hFFFF_FFF7, 0,  1'b0}
    };

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;
    logic         s_tuser  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;

    // Behavioural parser state.
    logic [5:0]   parse_pos        = '0;
    bit           parse_open       = 1'b0;
    logic [31:0]  byte_window      = '0;
    logic [31:0]  seen_file_size   = '0;
    logic [31:0]  seen_width       = '0;
    logic [31:0]  seen_neg_height  = '0;
    logic [31:0]  seen_pixel_bytes = '0;
    bhv_status_t  first_fault      = ST_OK;

    hdr_report_t  header_reports[$];
    hdr_report_t  due_report;
    int           fail_count    = 0;
    int           bytes_taken   = 0;
    int           reports_made  = 0;
    int           burst_left    = 0;
    logic [9:0]   stall_phase   = '0;

    bmp_header_validator DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // Only the first failed check in a header counts.
    function automatic void record_fault(input bit bad, input bhv_status_t code);
        if (bad && first_fault == ST_OK) begin
            first_fault = code;
        end
    endfunction

    // Advances the parser by one accepted byte. took is low when the byte is
    // ignored; done is high when the byte completes a header, and report then
    // holds what the block should send.
    function automatic void parse_header_byte(input logic [7:0] b, input logic st,
                                              output bit took, output bit done,
                                              output hdr_report_t report);
        logic [31:0] row_bytes;
        logic [31:0] area;
        took   = 1'b0;
        done   = 1'b0;
        report = '0;
        if (st) begin
            parse_pos        = '0;
            parse_open       = 1'b1;
            byte_window      = '0;
            seen_file_size   = '0;
            seen_width       = '0;
            seen_neg_height  = '0;
            seen_pixel_bytes = '0;
            first_fault      = ST_OK;
        end else if (!parse_open) begin
            return;
        end
        took        = 1'b1;
        // The window holds the last four bytes with the newest at the top, so a
        // 16-bit field sits in the upper half once its second byte is in.
        byte_window = {b, byte_window[31:8]};
        case (parse_pos)
            6'd1:  record_fault(byte_window[31:16] != BM_MAGIC, ST_SIG);
            6'd5:  seen_file_size = byte_window;
            6'd7:  record_fault(byte_window[31:16] != 16'd0, ST_RES1);
            6'd9:  record_fault(byte_window[31:16] != 16'd0, ST_RES2);
            6'd13: record_fault(byte_window != DATA_OFFSET, ST_OFFSET);
            6'd17: record_fault(byte_window != INFO_SIZE, ST_HDR_SIZE);
            6'd21: seen_width = byte_window;
            6'd25: begin
                record_fault(!byte_window[31], ST_BOTTOM_UP);
                seen_neg_height = -byte_window;
            end
            6'd27: record_fault(byte_window[31:16] != ONE_PLANE, ST_PLANES);
            6'd29: record_fault(byte_window[31:16] != TRUE_COLOUR, ST_BPP);
            6'd33: record_fault(byte_window != 32'd0, ST_COMPR);
            6'd37: begin
                // Rows are padded to four bytes; all of this wraps at 32 bits.
                seen_pixel_bytes = byte_window;
                row_bytes        = (seen_width * 32'd3 + 32'd3) & ~32'd3;
                area             = row_bytes * seen_neg_height;
                record_fault(area != byte_window, ST_IMG_SIZE);
            end
            6'd49: record_fault(byte_window != 32'd0, ST_USED);
            6'd53: record_fault(byte_window != 32'd0, ST_IMPORTANT);
            default: ;
        endcase
        if (parse_pos == 6'(HDR_LEN - 1)) begin
            done          = 1'b1;
            report.status = first_fault;
            if (first_fault == ST_OK) begin
                report.file_size   = seen_file_size;
                report.width       = seen_width;
                report.height      = seen_neg_height;
                report.pixel_bytes = seen_pixel_bytes;
            end
            parse_open = 1'b0;
            parse_pos  = '0;
        end else begin
            parse_pos = parse_pos + 6'd1;
        end
    endfunction

    // A well-formed header for the given width and (stored) height.
    function automatic bmp_hdr_t make_header(input logic [31:0] w, input logic [31:0] ht);
        bmp_hdr_t    hd;
        logic [31:0] row_bytes;
        row_bytes    = (w * 32'd3 + 32'd3) & ~32'd3;
        hd           = '0;
        hd.sig       = BM_MAGIC;
        hd.file_size = $urandom;
        hd.offset    = DATA_OFFSET;
        hd.info_size = INFO_SIZE;
        hd.width     = w;
        hd.height    = ht;
        hd.planes    = ONE_PLANE;
        hd.bpp       = TRUE_COLOUR;
        hd.img_size  = row_bytes * (-ht);
        hd.xres      = $urandom;
        hd.yres      = $urandom;
        return hd;
    endfunction

    // Spoils the field behind one check. The pattern must be non-zero in the
    // field's width, except for the height, which is replaced by a non-negative
    // value taken from it.
    function automatic bmp_hdr_t break_check(input bmp_hdr_t hd, input bhv_status_t code,
                                             input logic [31:0] mask);
        case (code)
            ST_SIG:       hd.sig       ^= mask[15:0];
            ST_RES1:      hd.res1      ^= mask[15:0];
            ST_RES2:      hd.res2      ^= mask[15:0];
            ST_OFFSET:    hd.offset    ^= mask;
            ST_HDR_SIZE:  hd.info_size ^= mask;
            ST_BOTTOM_UP: hd.height     = mask & 32'h7FFF_FFFF;
            ST_PLANES:    hd.planes    ^= mask[15:0];
            ST_BPP:       hd.bpp       ^= mask[15:0];
            ST_COMPR:     hd.compr     ^= mask;
            ST_IMG_SIZE:  hd.img_size  ^= mask;
            ST_USED:      hd.used      ^= mask;
            ST_IMPORTANT: hd.important ^= mask;
            default: ;
        endcase
        return hd;
    endfunction

    function automatic logic [31:0] spoil_mask();
        logic [31:0] mask;
        mask = $urandom;
        if (mask[15:0] == 16'd0) begin
            mask[0] = 1'b1;
        end
        return mask;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endfunction

    // Sends one request on the byte channel. The sender works in bursts; at the end
    // of each burst it drops tvalid for a short random pause. Once the byte is taken it is
    // run through the parser, and a finished header's report joins the queue,
    // replaced by the typed status where the directed table gives one.
    task automatic send_byte(input logic [7:0] b, input logic st, input bit typed,
                             input bhv_status_t typed_status);
        bit          took;
        bit          done;
        hdr_report_t report;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= st;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        parse_header_byte(b, st, took, done, report);
        if (took) begin
            bytes_taken++;
        end
        if (done) begin
            reports_made++;
            if (typed) begin
                report        = '0;
                report.status = typed_status;
            end
            header_reports.push_back(report);
        end
    endtask

    task automatic send_header(input bmp_hdr_t hd, input int nbytes, input bit typed,
                               input bhv_status_t typed_status);
        logic [HDR_BITS-1:0] flat;
        flat = hd;
        for (int i = 0; i < nbytes; i++) begin
            send_byte(flat[i*8 +: 8], i == 0, typed, typed_status);
        end
    endtask

    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, ST_OK);
        end
    endtask

    // Holds the sender off until every outstanding header has been reported.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (header_reports.size() != 0) @(posedge aclk);
        burst_left = 0;
    endtask

    // The receiver cycles through four stall patterns, chosen by the top two phase bits:
    // always ready, mostly ready, ready when the low three phase bits are zero, and a coin toss.
    always @(posedge aclk) begin
        stall_phase <= stall_phase + 10'd1;
        case (stall_phase[9:8])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_tready <= (stall_phase[2:0] == 3'd0);
            default: m_tready <= ($urandom_range(0, 1) == 0);
        endcase
    end

    // Every result request is matched against the oldest outstanding header.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (header_reports.size() == 0) begin
                $error("result request with no header outstanding");
                fail_count++;
            end else begin
                due_report = header_reports.pop_front();
                check_field("status", 32'(due_report.status), 32'(m_tdata[3:0]));
                check_field("file_size", due_report.file_size, m_tdata[35:4]);
                check_field("image_width", due_report.width, m_tdata[67:36]);
                check_field("image_height", due_report.height, m_tdata[99:68]);
                check_field("pixel_bytes", due_report.pixel_bytes, m_tdata[131:100]);
                check_field("padding", 32'd0, 32'(m_tdata[135:132]));
            end
        end
    end

    initial begin : stimulus
        dir_row_t            row;
        bmp_hdr_t            hd;
        logic [HDR_BITS-1:0] flat;
        logic [31:0]         w;
        logic [31:0]         ht;
        int                  kind;
        int                  cut;
        int                  pos;
        int                  code;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed cases from the table.
        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            send_noise(row.noise);
            hd = break_check(make_header(row.width, row.height), row.broken, row.mask);
            send_header(hd, (row.cut == 0) ? HDR_LEN : row.cut, row.typed, row.broken);
        end
        drain_results();

        // Random headers, mostly well formed so that the image size check is
        // reached, the rest spoiled, scrambled, abandoned or led by stray bytes.
        bytes_taken  = 0;
        reports_made = 0;
        while (bytes_taken < RANDOM_BYTES || reports_made < RANDOM_REPORTS) begin
            kind = $urandom_range(0, 99);
            if ($urandom_range(0, 3) != 0) begin
                w  = $urandom_range(0, 64);
                ht = 32'd0 - $urandom_range(1, 64);
            end else begin
                w  = $urandom;
                ht = $urandom | 32'h8000_0000;
            end
            hd  = make_header(w, ht);
            cut = HDR_LEN;
            if (kind < 55) begin
                // Well formed.
            end else if (kind < 78) begin
                code = $urandom_range(int'(ST_SIG), int'(ST_IMPORTANT));
                hd   = break_check(hd, bhv_status_t'(code), spoil_mask());
                // A second, later failure must not hide the first.
                if (code < int'(ST_IMPORTANT) && $urandom_range(0, 2) == 0) begin
                    code = $urandom_range(code + 1, int'(ST_IMPORTANT));
                    hd   = break_check(hd, bhv_status_t'(code), spoil_mask());
                end
            end else if (kind < 86) begin
                flat = hd;
                pos  = $urandom_range(0, HDR_LEN - 1);
                flat[pos*8 +: 8] ^= 8'($urandom_range(1, 255));
                hd = bmp_hdr_t'(flat);
            end else if (kind < 91) begin
                for (int i = 0; i < HDR_LEN; i++) begin
                    flat[i*8 +: 8] = 8'($urandom_range(0, 255));
                end
                hd = bmp_hdr_t'(flat);
            end else if (kind < 97) begin
                cut = $urandom_range(1, HDR_LEN - 1);
            end else begin
                // Stray bytes, now and then with a start flag of their own.
                for (int i = $urandom_range(1, 4); i > 0; i--) begin
                    send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0),
                              1'b0, ST_OK);
                end
            end
            send_header(hd, cut, 1'b0, ST_OK);
            if ($urandom_range(0, 29) == 0) begin
                drain_results();
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (header_reports.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // A correct run needs well under a tenth of this.
    initial begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
